// ----- rtl/mvsf_pkg.sv -----
// Package for the memory value scan filter: operation codes, word types,
// controller states and the command group between controller and datapath.
// No dependencies.
package mvsf_pkg;

	localparam int unsigned LIST_DEPTH_DEF = 1024;
	localparam int unsigned PAGE_BYTES_DEF = 4096;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_SCAN   = 2'd1,
		OP_REFINE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] byte_address;
		logic [7:0]  data_byte;
		logic        page_ok;
		logic [31:0] read_word;
		logic        read_ok;
		logic        refine_start;
		logic [9:0]  entry_index;
	} in_word_t;

	typedef struct packed {
		logic        match_found;
		logic [31:0] match_address;
		logic [10:0] list_count;
		logic        list_full;
		logic        entry_valid;
	} out_word_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

endpackage

// ----- rtl/mvsf_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module mvsf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/mvsf_ctrl.sv -----
// Controller of the memory value scan filter: capture and execute sequencing
// and the output valid flag. Depends on mvsf_pkg.
module mvsf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output mvsf_pkg::ctrl_cmd_t cmd
);

	mvsf_pkg::state_t state_q, state_next;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			mvsf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = mvsf_pkg::ST_EXEC;
				end
			end
			mvsf_pkg::ST_EXEC: begin
				if (slot_free) begin
					state_next = mvsf_pkg::ST_IDLE;
				end
			end
			default: state_next = mvsf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			mvsf_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			mvsf_pkg::ST_EXEC: begin
				cmd.execute = slot_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mvsf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_next;
			out_valid_q <= cmd.execute || (out_valid_q && out_stall);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/mvsf_datapath.sv -----
// Datapath of the memory value scan filter: search register, byte window,
// list count and refine cursors, address list memory and output register.
// Depends on mvsf_pkg and mvsf_ram.
module mvsf_datapath #(
	parameter int unsigned LIST_DEPTH = mvsf_pkg::LIST_DEPTH_DEF,
	parameter int unsigned PAGE_BYTES = mvsf_pkg::PAGE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  mvsf_pkg::ctrl_cmd_t cmd,
	input  mvsf_pkg::in_word_t  in_word,
	output mvsf_pkg::out_word_t out_word
);

	localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
	localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

	logic [31:0]        search_q;
	logic [CNT_W-1:0]   count_q, count_n;
	logic [CNT_W-1:0]   cursor_q, cursor_n;
	logic [CNT_W-1:0]   orig_q, orig_n;
	logic [23:0]        window_q, window_n;
	mvsf_pkg::in_word_t item_q;
	mvsf_pkg::out_word_t out_q, out_n;

	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;

	logic [OFF_W-1:0]   offset;
	logic [23:0]        win_use;
	logic [31:0]        scan_word;
	logic               scan_hit;
	logic [CNT_W-1:0]   eff_orig, eff_cur, eff_cnt;
	logic [31:0]        read_idx;

	assign ram_re    = cmd.capture;
	assign ram_raddr = (in_word.op == mvsf_pkg::OP_READ) ? IDX_W'(in_word.entry_index) :
		(in_word.refine_start ? '0 : IDX_W'(cursor_q));

	mvsf_ram #(
		.WIDTH(32),
		.DEPTH(LIST_DEPTH)
	) u_list (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign offset    = item_q.byte_address[OFF_W-1:0];
	assign win_use   = (offset == '0) ? '0 : window_q;
	assign scan_word = {item_q.data_byte, win_use};
	assign scan_hit  = (offset >= OFF_W'(3)) && item_q.page_ok && (scan_word == search_q);
	assign eff_orig  = item_q.refine_start ? count_q : orig_q;
	assign eff_cur   = item_q.refine_start ? '0 : cursor_q;
	assign eff_cnt   = item_q.refine_start ? '0 : count_q;
	assign read_idx  = 32'(item_q.entry_index);

	always_comb begin
		count_n   = count_q;
		cursor_n  = cursor_q;
		orig_n    = orig_q;
		window_n  = window_q;
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(count_q);
		ram_wdata = ram_rdata;
		out_n     = '0;
		unique case (item_q.op)
			mvsf_pkg::OP_CLEAR: begin
				count_n  = '0;
				cursor_n = '0;
				orig_n   = '0;
				window_n = '0;
			end
			mvsf_pkg::OP_SCAN: begin
				window_n = scan_word[31:8];
				if (scan_hit) begin
					out_n.match_address = item_q.byte_address - 32'd3;
					ram_wdata           = item_q.byte_address - 32'd3;
					if (count_q < DEPTH_C) begin
						ram_we            = 1'b1;
						count_n           = count_q + 1'b1;
						out_n.match_found = 1'b1;
					end else begin
						out_n.list_full = 1'b1;
					end
				end
			end
			mvsf_pkg::OP_REFINE: begin
				orig_n    = eff_orig;
				cursor_n  = eff_cur;
				count_n   = eff_cnt;
				ram_waddr = IDX_W'(eff_cnt);
				if ((eff_cur < eff_orig) && (eff_cur < DEPTH_C)) begin
					cursor_n          = eff_cur + 1'b1;
					out_n.entry_valid = 1'b1;
					if (item_q.read_ok && (item_q.read_word == search_q) &&
						(eff_cnt < DEPTH_C)) begin
						ram_we              = 1'b1;
						count_n             = eff_cnt + 1'b1;
						out_n.match_found   = 1'b1;
						out_n.match_address = ram_rdata;
					end
				end
			end
			mvsf_pkg::OP_READ: begin
				if ((read_idx < 32'(count_q)) && (read_idx < 32'(LIST_DEPTH))) begin
					out_n.entry_valid   = 1'b1;
					out_n.match_address = ram_rdata;
				end
			end
			default: count_n = count_q;
		endcase
		ram_we           = ram_we && cmd.execute;
		out_n.list_count = 11'(count_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_q <= '0;
			count_q  <= '0;
			cursor_q <= '0;
			orig_q   <= '0;
			window_q <= '0;
		end else begin
			if (cfg_we) begin
				search_q <= cfg_wdata;
			end
			if (cmd.execute) begin
				count_q  <= count_n;
				cursor_q <= cursor_n;
				orig_q   <= orig_n;
				window_q <= window_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_word;
		end
		if (cmd.execute) begin
			out_q <= out_n;
		end
	end

	assign out_word = out_q;

endmodule

// ----- rtl/memory_value_scan_filter_unit.sv -----
// Top level of the memory value scan filter: controller, datapath and list memory.
// Depends on mvsf_pkg, mvsf_ctrl and mvsf_datapath.
//
// Input words carry an operation: clear the list, scan one byte, refine the
// next stored entry or read an entry back by index. Scanned bytes must arrive
// in address order; a match stores the start address of the 32-bit word that
// ends on the byte. Each input word gives exactly one output word.
// A word is taken in the idle state, which issues its list memory read; the
// execute state, once the output register is free, does the update and list
// write and loads the output register and the valid flag. No new word is
// taken until the last one is executed; the registered list memory read sets
// this. While an output word waits under out_stall the block still accepts
// one more input word, and then stalls the input until the output register
// frees. The user must write the search value through cfg_we and cfg_wdata
// only while the block is idle; the block itself does not enforce this. Reset
// clears the count, window, cursors, search value and output valid; the list
// memory is not cleared, and an entry is only read once written.
module memory_value_scan_filter_unit #(
	parameter int unsigned LIST_DEPTH = mvsf_pkg::LIST_DEPTH_DEF,
	parameter int unsigned PAGE_BYTES = mvsf_pkg::PAGE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  mvsf_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output mvsf_pkg::out_word_t out_word
);

	mvsf_pkg::ctrl_cmd_t cmd;

	mvsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	mvsf_datapath #(
		.LIST_DEPTH(LIST_DEPTH),
		.PAGE_BYTES(PAGE_BYTES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.in_word  (in_word),
		.out_word (out_word)
	);

endmodule

// ----- rtl/mvsf_checker.sv -----
// Port checker for the memory value scan filter and its bind to the top level.
// Depends on mvsf_pkg.
module mvsf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input mvsf_pkg::out_word_t out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Output valid dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("Output word changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input taken in two consecutive cycles.");

	a_full_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.list_full |-> !out_word.match_found && !out_word.entry_valid)
		else $error("Dropped match reported as stored or as a valid entry.");

endmodule

bind memory_value_scan_filter_unit mvsf_checker u_mvsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);

// ----- sim/mvsf_checker.sv -----
// Checker for the memory value scan filter: watches the configuration port and both word
// channels, keeps its own copy of the list, window and refine cursors, and compares results.
// Depends on mvsf_pkg.
module mvsf_scoreboard
	import mvsf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_word_t  in_word,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_word_t out_word,
	output int        fail_count,
	output int        words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [10:0] DEPTH = 11'(LIST_DEPTH_DEF);

	logic [31:0] list_mem [0:LIST_DEPTH_DEF-1];
	logic [10:0] list_len = '0;
	logic [23:0] window = '0;
	logic [10:0] cursor = '0;
	logic [10:0] snapshot_len = '0;
	logic [31:0] target_value = '0;
	out_word_t   result_words_due [$];

	function automatic out_word_t scan_filter_step(in_word_t w);
		out_word_t   r;
		logic [31:0] page_offset;
		logic [31:0] word_seen;
		logic [31:0] kept_addr;
		r = '0;
		case (w.op)
		OP_CLEAR: begin
			list_len = '0;
			window = '0;
			cursor = '0;
			snapshot_len = '0;
		end
		OP_SCAN: begin
			page_offset = w.byte_address % PAGE_BYTES_DEF;
			if (page_offset == 0) window = '0;
			word_seen = {w.data_byte, window};
			window = word_seen[31:8];
			if (page_offset >= 3 && w.page_ok && word_seen == target_value) begin
				r.match_address = w.byte_address - 32'd3;
				if (list_len < DEPTH) begin
					list_mem[list_len[9:0]] = r.match_address;
					list_len++;
					r.match_found = 1'b1;
				end else begin
					r.list_full = 1'b1;
				end
			end
		end
		OP_REFINE: begin
			if (w.refine_start) begin
				snapshot_len = list_len;
				cursor = '0;
				list_len = '0;
			end
			if (cursor < snapshot_len) begin
				kept_addr = list_mem[cursor[9:0]];
				cursor++;
				r.entry_valid = 1'b1;
				if (w.read_ok && w.read_word == target_value && list_len < DEPTH) begin
					list_mem[list_len[9:0]] = kept_addr;
					list_len++;
					r.match_found = 1'b1;
					r.match_address = kept_addr;
				end
			end
		end
		OP_READ: begin
			if (11'(w.entry_index) < list_len) begin
				r.entry_valid = 1'b1;
				r.match_address = list_mem[w.entry_index];
			end
		end
		endcase
		r.list_count = list_len;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : watch
		out_word_t want;
		if (arst_n) begin
			if (cfg_we) target_value = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (result_words_due.size() == 0) begin
					report_mismatch("word with none due", out_word.match_address, '0);
				end else begin
					want = result_words_due.pop_front();
					compare_field("match_found", 32'(out_word.match_found),
						32'(want.match_found));
					compare_field("match_address", out_word.match_address,
						want.match_address);
					compare_field("list_count", 32'(out_word.list_count),
						32'(want.list_count));
					compare_field("list_full", 32'(out_word.list_full),
						32'(want.list_full));
					compare_field("entry_valid", 32'(out_word.entry_valid),
						32'(want.entry_valid));
				end
			end
			if (in_valid && !in_stall) result_words_due.push_back(scan_filter_step(in_word));
			words_due = result_words_due.size();
		end
	end

endmodule

// ----- sim/memory_value_scan_filter_unit_tb.sv -----
// Testbench top for the memory value scan filter: clock, reset, stimulus and verdict.
// Depends on mvsf_pkg, memory_value_scan_filter_unit and mvsf_scoreboard.
module memory_value_scan_filter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mvsf_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 50;
	localparam int PHASES = 8;
	localparam int FILL_ITEMS = 1040;
	localparam logic [31:0] FILL_BASE = 32'h8000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;
	int          fail_count;
	int          words_due;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_ack = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          items_sent = 0;
	logic [31:0] search_value = '0;

	memory_value_scan_filter_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	mvsf_scoreboard i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.fail_count(fail_count),
		.words_due (words_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_word_t any_word(op_t op);
		in_word_t w;
		w.op = op;
		w.byte_address = $urandom();
		w.data_byte = 8'($urandom());
		w.page_ok = 1'($urandom());
		w.read_word = $urandom();
		w.read_ok = 1'($urandom());
		w.refine_start = 1'($urandom());
		w.entry_index = 10'($urandom());
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic clear_list();
		send_word(any_word(OP_CLEAR));
	endtask

	task automatic scan_byte(logic [31:0] addr, logic [7:0] b, logic ok);
		in_word_t w;
		w = any_word(OP_SCAN);
		w.byte_address = addr;
		w.data_byte = b;
		w.page_ok = ok;
		send_word(w);
	endtask

	task automatic refine_entry(logic start, logic [31:0] rword, logic rok);
		in_word_t w;
		w = any_word(OP_REFINE);
		w.refine_start = start;
		w.read_word = rword;
		w.read_ok = rok;
		send_word(w);
	endtask

	task automatic read_entry(logic [9:0] idx);
		in_word_t w;
		w = any_word(OP_READ);
		w.entry_index = idx;
		send_word(w);
	endtask

	task automatic write_search(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		search_value = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic scan_run(logic [31:0] start, int len, int ok_mode);
		logic [31:0] addr;
		logic [7:0]  b;
		logic        ok;
		int          planted;
		int          k;
		addr = start;
		planted = 0;
		for (k = 0; k < len; k++) begin
			if (planted == 0 && $urandom_range(7) == 0) planted = 4;
			if (planted > 0) begin
				b = search_value[8 * (4 - planted) +: 8];
				planted--;
			end else if ($urandom_range(3) == 0) begin
				b = search_value[8 * $urandom_range(3) +: 8];
			end else begin
				b = 8'($urandom());
			end
			case (ok_mode)
			0: ok = 1'b1;
			1: ok = 1'b0;
			default: ok = ($urandom_range(9) != 0);
			endcase
			scan_byte(addr, b, ok);
			addr++;
		end
	endtask

	task automatic refine_pass(int len);
		int k;
		for (k = 0; k < len; k++) begin
			refine_entry(k == 0 && $urandom_range(9) != 0,
				($urandom_range(9) < 6) ? search_value : $urandom(),
				$urandom_range(19) != 0);
		end
	endtask

	initial begin
		logic [31:0] start;
		int          phase;
		int          stop_at;
		int          pick;
		int          k;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Search value is zero after reset, so zero bytes match wherever the page allows.
		clear_list();
		scan_byte(32'h0000_0FFE, 8'h00, 1'b1);
		scan_byte(32'h0000_1000, 8'h00, 1'b1);
		scan_byte(32'h0000_1001, 8'h00, 1'b1);
		scan_byte(32'h0000_1002, 8'h00, 1'b1);
		scan_byte(32'h0000_1003, 8'h00, 1'b1);
		scan_byte(32'h0000_1004, 8'h00, 1'b0);
		scan_byte(32'hFFFF_FFFF, 8'h00, 1'b1);
		read_entry(10'd0);
		read_entry(10'd2);
		refine_entry(1'b1, 32'h0000_0000, 1'b1);
		refine_entry(1'b0, 32'h0000_0000, 1'b0);
		refine_entry(1'b0, 32'hFFFF_FFFF, 1'b1);
		read_entry(10'd0);
		read_entry(10'd2);
		wait_drain();
		write_search(32'hFFFF_FFFF);
		for (k = 0; k < 4; k++) scan_byte(32'h0000_2000 + k, 8'hFF, 1'b1);
		read_entry(10'd1);

		// Fill every list entry and run past the end so that matches are dropped.
		wait_drain();
		write_search(32'hA5A5_A5A5);
		clear_list();
		for (k = 0; k < FILL_ITEMS; k++) scan_byte(FILL_BASE + k, 8'hA5, 1'b1);
		read_entry(10'd1023);
		read_entry(10'd0);

		for (phase = 0; phase < PHASES; phase++) begin
			wait_drain();
			case (phase)
			0: write_search(32'h0000_0000);
			1: write_search(32'hFFFF_FFFF);
			default: write_search($urandom());
			endcase
			case (phase % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 51;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 51;
			end
			default: begin
				send_idle_pct = 28;
				recv_stall_pct = 28;
			end
			endcase
			if (phase == 4) hold_req <= ~hold_req;
			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					case ($urandom_range(2))
					0: start = $urandom() & ~32'hFFF;
					1: start = ($urandom() | 32'hFFF) - $urandom_range(20);
					default: start = $urandom();
					endcase
					scan_run(start, $urandom_range(8, 60),
						($urandom_range(9) == 0) ? 1 : ($urandom_range(9) == 0) ? 2 : 0);
				end else if (pick < 70) begin
					refine_pass($urandom_range(1, 40));
				end else if (pick < 85) begin
					for (k = $urandom_range(1, 6); k > 0; k--) begin
						read_entry($urandom_range(1) ? 10'($urandom_range(63)) : 10'($urandom()));
					end
				end else if (pick < 90) begin
					clear_list();
				end else begin
					send_word(any_word(op_t'($urandom_range(3))));
				end
			end
		end

		wait_drain();
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
